// ===== hdl/srb_pkg.sv =====
package srb_pkg;

    localparam int DepthDef  = 1024;
    localparam int SampleW   = 16;
    localparam int IndexW    = 16;
    localparam int MagW      = IndexW + 1;
    localparam int IntervalW = 11;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    // Status of the remainder unit as seen by the top level.
    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [IntervalW-1:0] rem;
    } t_rem_stat;

endpackage

// ===== hdl/srb_ram.sv =====
module srb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/srb_rem.sv =====
module srb_rem #(
    parameter int DIVIDEND_W = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [DIVIDEND_W-1:0]             i_dividend,
    input  logic [srb_pkg::IntervalW-1:0]     i_divisor,
    output srb_pkg::t_rem_stat                o_stat
);

    localparam int NW = $clog2(DIVIDEND_W + 1);
    localparam int RW = srb_pkg::IntervalW + 1;

    logic                              r_busy;
    logic [NW-1:0]                     r_cnt;
    logic [DIVIDEND_W-1:0]             r_dvd;
    logic [RW-1:0]                     r_rem;
    logic [srb_pkg::IntervalW-1:0]     r_div;
    logic [RW-1:0]                     trial;
    logic [RW-1:0]                     n_rem;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        trial = {r_rem[srb_pkg::IntervalW-1:0], r_dvd[DIVIDEND_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= NW'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - NW'(1);
            if (r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == NW'(1));
    assign o_stat.rem  = n_rem[srb_pkg::IntervalW-1:0];

endmodule

// ===== hdl/sample_ring_buffer_interval_tick.sv =====
// Channel  Valid        Stall        Payload
// input    i_in_valid   o_in_stall   i_operation, i_sample, i_read_index
// output   o_out_valid  i_out_stall  o_read_data, o_last_sample, o_interval_tick, o_wrapped
// config   i_cfg_we     (none)       i_cfg_data
//
// One item is accepted per cycle while the input is not stalled; its result passes
// through the sample RAM's registered read and then the output register.
// After a write to the interval register, input is held off while the serial
// remainder unit works out the tick phase from the write counter (11 bits wide at
// the default depth).
// Reset is synchronous and active low; the RAM needs no clearing pass, since unwritten
// entries are masked to zero by the fill count.
// An output stall holds the result and, once the middle stage is full, stalls the input.
module sample_ring_buffer_interval_tick #(
    parameter int DEPTH = srb_pkg::DepthDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srb_pkg::IntervalW-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [srb_pkg::SampleW-1:0]       i_sample,
    input  logic signed [srb_pkg::IndexW-1:0] i_read_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [srb_pkg::SampleW-1:0]       o_read_data,
    output logic [srb_pkg::SampleW-1:0]       o_last_sample,
    output logic                              o_interval_tick,
    output logic                              o_wrapped
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = srb_pkg::MagW;
    localparam int IW = srb_pkg::IntervalW;
    localparam int SW = srb_pkg::SampleW;

    localparam logic [MW-1:0] MaxIdx  = MW'(DEPTH - 1);
    localparam logic [CW-1:0] DepthC  = CW'(DEPTH);
    localparam logic [AW:0]   DepthS  = (AW + 1)'(DEPTH);

    logic [IW-1:0]  r_interval;
    logic [CW-1:0]  r_tick_count;
    logic [IW-1:0]  r_phase;
    logic           r_wrapped;
    logic [SW-1:0]  r_newest;

    logic           r_s1_v;
    logic           r_s1_rd;
    logic [SW-1:0]  r_s1_last;
    logic           r_s1_tick;
    logic           r_s1_wrap;

    logic           r_o_v;
    logic [SW-1:0]  r_o_data;
    logic [SW-1:0]  r_o_last;
    logic           r_o_tick;
    logic           r_o_wrap;

    srb_pkg::t_rem_stat rem_stat;

    logic           in_acc;
    logic           wr_acc;
    logic           rd_acc;
    logic           out_free;
    logic           s1_move;
    logic [MW-1:0]  mag;
    logic [AW-1:0]  idx;
    logic [AW-1:0]  fill;
    logic [AW:0]    rd_sum;
    logic [AW-1:0]  rd_addr;
    logic           rd_hit;
    logic           wrap_now;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  ram_addr;
    logic [SW-1:0]  ram_rdata;
    logic [IW-1:0]  phase_inc;
    logic [CW-1:0]  n_tick_count;
    logic [IW-1:0]  n_phase;
    logic           n_wrapped;
    logic           n_tick;

    srb_rem #(
        .DIVIDEND_W (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cfg_we),
        .i_dividend (r_tick_count),
        .i_divisor  (i_cfg_data),
        .o_stat     (rem_stat)
    );

    srb_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_acc),
        .i_re    (rd_acc),
        .i_addr  (ram_addr),
        .i_wdata (i_sample),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_o_v || !i_out_stall;
    assign s1_move    = r_s1_v && out_free;
    assign o_in_stall = rem_stat.busy || i_cfg_we || (r_s1_v && !out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_acc     = in_acc && (i_operation == srb_pkg::OP_WRITE);
    assign rd_acc     = in_acc && (i_operation == srb_pkg::OP_READ);

    // Read address: magnitude, saturation, then oldest-first once wrapped.
    always_comb begin
        if (i_read_index[srb_pkg::IndexW-1]) begin
            mag = MW'(17'h10000) - {1'b0, i_read_index};
        end else begin
            mag = {1'b0, i_read_index};
        end
        if (mag > MaxIdx) begin
            idx = MaxIdx[AW-1:0];
        end else begin
            idx = mag[AW-1:0];
        end
        if (r_tick_count == DepthC) begin
            fill = '0;
        end else begin
            fill = r_tick_count[AW-1:0];
        end
        rd_sum = {1'b0, fill} + {1'b0, idx};
        if (rd_sum >= DepthS) begin
            rd_addr = AW'(rd_sum - DepthS);
        end else begin
            rd_addr = rd_sum[AW-1:0];
        end
        rd_hit = r_wrapped || (CW'(idx) < r_tick_count);
    end

    // Write position, pass count and tick phase.
    always_comb begin
        wrap_now  = (r_tick_count >= DepthC);
        phase_inc = r_phase + IW'(1);
        if (wrap_now) begin
            wr_addr      = '0;
            n_tick_count = CW'(1);
            n_wrapped    = 1'b1;
            n_phase      = (r_interval == IW'(1)) ? '0 : IW'(1);
        end else begin
            wr_addr      = r_tick_count[AW-1:0];
            n_tick_count = r_tick_count + CW'(1);
            n_wrapped    = r_wrapped;
            n_phase      = (phase_inc == r_interval) ? '0 : phase_inc;
        end
        n_tick = (r_interval != '0) && (n_phase == '0);
    end

    assign ram_addr = (i_operation == srb_pkg::OP_WRITE) ? wr_addr :
                      (r_wrapped ? rd_addr : idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= '0;
            r_tick_count <= '0;
            r_phase      <= '0;
            r_wrapped    <= 1'b0;
            r_newest     <= '0;
            r_s1_v       <= 1'b0;
            r_o_v        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            if (rem_stat.done) begin
                r_phase <= rem_stat.rem;
            end else if (wr_acc) begin
                r_phase <= n_phase;
            end
            if (wr_acc) begin
                r_tick_count <= n_tick_count;
                r_wrapped    <= n_wrapped;
                r_newest     <= i_sample;
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (out_free) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd   <= rd_acc && rd_hit;
            r_s1_last <= wr_acc ? i_sample : r_newest;
            r_s1_tick <= wr_acc && n_tick;
            r_s1_wrap <= wr_acc ? n_wrapped : r_wrapped;
        end
        if (s1_move) begin
            r_o_data <= r_s1_rd ? ram_rdata : '0;
            r_o_last <= r_s1_last;
            r_o_tick <= r_s1_tick;
            r_o_wrap <= r_s1_wrap;
        end
    end

    assign o_out_valid     = r_o_v;
    assign o_read_data     = r_o_data;
    assign o_last_sample   = r_o_last;
    assign o_interval_tick = r_o_tick;
    assign o_wrapped       = r_o_wrap;

    a_wrap_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrapped |=> r_wrapped)
        else $error("Wrapped flag dropped after the store filled.");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick_count <= DepthC) && (!r_wrapped || r_tick_count != '0))
        else $error("Write count left its range.");

    a_busy_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.busy |-> !in_acc)
        else $error("An item was taken while the tick phase was being computed.");

    a_tick_no_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_interval_tick) |-> (o_read_data == '0))
        else $error("A tick came with read data.");

endmodule
